FILE: design/b64_pkg.sv
// shared types, constants and character mapping functions for the base64 codec
package b64_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

  localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='
  localparam logic [0:0] DIR_ENCODE = 1'b0;
  localparam logic [0:0] DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       bad_char;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]  cnt;
  } batch_t;

  typedef struct packed {
    logic [15:0] group_bytes;
    logic [1:0]  group_count;
  } enc_state_t;

  typedef struct packed {
    logic [11:0] bit_accum;
    logic [3:0]  bit_count;
    logic        pad_seen;
    logic        error_seen;
  } dec_state_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] ch;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      ch = w + 8'd65;
    end else if (v < 6'd52) begin
      ch = w + 8'd71;
    end else if (v < 6'd62) begin
      ch = w - 8'd4;
    end else if (v == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

  // character to {in alphabet, 6-bit value}
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [7:0] w;
    logic [6:0] r;
    w = 8'h00;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      w = c - 8'd65;
      r = {1'b1, w[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      w = c - 8'd71;
      r = {1'b1, w[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      w = c + 8'd4;
      r = {1'b1, w[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = {1'b0, w[5:0]};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

FILE: design/base64_codec.sv
// base64 codec top level: input register, codec state and configuration
//
// Streaming base64 codec, standard alphabet with '=' padding.
// Input channel: in_valid/in_stall with in_data_byte and in_last; a
// transaction moves on a clock edge where in_valid is high and in_stall low.
// Result channel: out_valid/out_stall with out_byte, out_byte_valid,
// out_last and out_bad_char, same rule.
// Configuration: cfg_valid/cfg_ready with cfg_direction (0 encode, 1 decode);
// cfg_ready is always high, write only while the codec is idle. A write
// clears all stream state.
// An accepted item is held in the input register; its results are then
// loaded into the result buffer and the first is offered the cycle after.
// The result buffer drains one result per cycle while out_stall is low.
// Decode takes one item per cycle while out_stall is low; encode holds the
// two bytes that open a group until the buffer is down to its last character.
// A stalled receiver holds the current result; one more input item is still
// taken into the input register, then in_stall rises.
// Reset (rst_n, synchronous, active low) selects encode and empties all
// stream state and buffers.
module base64_codec import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_bad_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       dir_r, dir_nxt;
  enc_state_t enc_r, enc_nxt, enc_step;
  dec_state_t dec_r, dec_nxt, dec_step;
  batch_t     enc_batch, dec_batch, batch;
  logic       can_load;
  logic       process;
  logic       accept;
  logic       cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = in_vld_r && !can_load;
  assign accept    = in_valid && !in_stall;
  assign process   = in_vld_r && can_load;

  b64_enc u_enc (
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .st        (enc_r),
    .st_nxt    (enc_step),
    .batch     (enc_batch)
  );

  b64_dec u_dec (
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .st        (dec_r),
    .st_nxt    (dec_step),
    .batch     (dec_batch)
  );

  assign batch = (dir_r == DIR_DECODE) ? dec_batch : enc_batch;

  b64_outbuf u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (process),
    .batch          (batch),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_bad_char   (out_bad_char)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (process) begin
      in_vld_nxt = 1'b0;
    end

    dir_nxt = dir_r;
    enc_nxt = enc_r;
    dec_nxt = dec_r;
    if (cfg_wr) begin
      dir_nxt = cfg_direction;
      enc_nxt = '0;
      dec_nxt = '0;
    end else if (process) begin
      if (dir_r == DIR_DECODE) begin
        dec_nxt = dec_step;
      end else begin
        enc_nxt = enc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      dir_r    <= DIR_ENCODE;
      enc_r    <= '0;
      dec_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      dir_r    <= dir_nxt;
      enc_r    <= enc_nxt;
      dec_r    <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last;
    end
  end

`ifndef SYNTH
  a_stream_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    process && in_last_r && !cfg_wr |=>
      enc_r.group_count == 2'd0 && dec_r.bit_count == 4'd0 &&
      !dec_r.pad_seen && !dec_r.error_seen)
    else $error("stream state not cleared after last transaction");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    dec_r.bit_count <= 4'd6 && !dec_r.bit_count[0])
    else $error("decode bit count out of range");

  a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
    enc_r.group_count != 2'd3)
    else $error("encode group count out of range");
`endif

endmodule

FILE: design/b64_enc.sv
// encode step: gathers bytes into groups of three and forms four characters
module b64_enc import b64_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic       last,
  input  enc_state_t st,
  output enc_state_t st_nxt,
  output batch_t     batch
);

  logic [23:0] n;
  logic [15:0] n16;
  logic [1:0]  have;
  logic        emit;

  always_comb begin
    st_nxt = st;
    n16    = 16'h0000;
    if (st.group_count == 2'd2) begin
      n    = {st.group_bytes, data_byte};
      have = 2'd3;
      emit = 1'b1;
      st_nxt.group_bytes = 16'h0000;
      st_nxt.group_count = 2'd0;
    end else begin
      n16  = (st.group_count == 2'd0) ? {data_byte, 8'h00} : {st.group_bytes[15:8], data_byte};
      n    = {n16, 8'h00};
      have = st.group_count + 2'd1;
      emit = last;
      st_nxt.group_bytes = n16;
      st_nxt.group_count = st.group_count + 2'd1;
    end
    if (last) begin
      st_nxt = '0;
    end
  end

  always_comb begin
    batch.cnt = emit ? RES_CNT_W'(MAX_RES) : '0;
    for (int i = 0; i < MAX_RES; i++) begin
      batch.res[i].out_byte   = (i <= int'(have)) ? enc_char(6'(n >> (18 - 6 * i))) : PAD_CHAR;
      batch.res[i].byte_valid = 1'b1;
      batch.res[i].out_last   = last && (i == MAX_RES - 1);
      batch.res[i].bad_char   = 1'b0;
    end
  end

endmodule

FILE: design/b64_dec.sv
// decode step: collects sextets into a 12-bit accumulator and releases bytes
module b64_dec import b64_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic       last,
  input  dec_state_t st,
  output dec_state_t st_nxt,
  output batch_t     batch
);

  logic [6:0]  sx;
  logic [11:0] acc_nxt;
  logic [3:0]  cnt_sum;
  logic [3:0]  cnt_left;
  logic        active;
  logic        take_bits;
  logic        emit_byte;

  always_comb begin
    sx        = dec_sextet(data_byte);
    active    = !st.pad_seen && !st.error_seen && !is_blank(data_byte);
    take_bits = active && (data_byte != PAD_CHAR) && sx[6];
    acc_nxt   = {st.bit_accum[5:0], sx[5:0]};
    cnt_sum   = st.bit_count + 4'd6;
    emit_byte = take_bits && (cnt_sum >= 4'd8);
    cnt_left  = emit_byte ? cnt_sum - 4'd8 : cnt_sum;

    st_nxt = st;
    if (active && data_byte == PAD_CHAR) begin
      st_nxt.pad_seen = 1'b1;
    end else if (active && !sx[6]) begin
      st_nxt.error_seen = 1'b1;
    end else if (take_bits) begin
      st_nxt.bit_accum = acc_nxt;
      st_nxt.bit_count = cnt_left;
    end

    batch = '0;
    if (emit_byte) begin
      batch.cnt                = RES_CNT_W'(1);
      batch.res[0].out_byte    = 8'(acc_nxt >> cnt_left);
      batch.res[0].byte_valid  = 1'b1;
      batch.res[0].out_last    = last;
      batch.res[0].bad_char    = st_nxt.error_seen;
    end else if (last) begin
      // bare end marker
      batch.cnt                = RES_CNT_W'(1);
      batch.res[0].out_last    = 1'b1;
      batch.res[0].bad_char    = st_nxt.error_seen;
    end

    if (last) begin
      st_nxt = '0;
    end
  end

endmodule

FILE: design/b64_outbuf.sv
// result buffer: holds one item's results and drains them one per cycle while out_stall is low
module b64_outbuf import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  batch_t     batch,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_bad_char
);

  result_t [MAX_RES-1:0] res_r;
  logic [RES_CNT_W-1:0]  left_r, left_nxt;
  logic [RES_IDX_W-1:0]  idx_r, idx_nxt;
  logic                  drain;
  result_t               cur;

  assign out_valid = (left_r != '0);
  assign drain     = out_valid && !out_stall;
  assign can_load  = (left_r == '0) || ((left_r == RES_CNT_W'(1)) && !out_stall);

  assign cur            = res_r[idx_r];
  assign out_byte       = cur.out_byte;
  assign out_byte_valid = cur.byte_valid;
  assign out_last       = cur.out_last;
  assign out_bad_char   = cur.bad_char;

  always_comb begin
    left_nxt = left_r;
    idx_nxt  = idx_r;
    if (load && batch.cnt != '0) begin
      left_nxt = batch.cnt;
      idx_nxt  = '0;
    end else if (drain) begin
      left_nxt = left_r - RES_CNT_W'(1);
      idx_nxt  = idx_r + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      idx_r  <= '0;
    end else begin
      left_r <= left_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && batch.cnt != '0) begin
      res_r <= batch.res;
    end
  end

`ifndef SYNTH
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= RES_CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && batch.cnt != '0 |-> (left_r == '0) || (left_r == RES_CNT_W'(1) && drain))
    else $error("results loaded over undelivered results");
`endif

endmodule
